// ----- src/gics_pkg.sv -----
// Shared types and constants for the group index channel shuffle block.
package gics_pkg;

  localparam int ElemW  = 32;
  localparam int GidxW  = 12;
  localparam int CountW = 13;
  localparam int BaseW  = GidxW + CountW;
  localparam int QDepth = 4;

  localparam logic [ElemW-1:0] NibLow  = 32'h0000_000F;
  localparam logic [ElemW-1:0] NibHigh = 32'h0000_00F0;

  // Configuration register indexes
  localparam logic [1:0] RegChannelsPerRow = 2'd0;
  localparam logic [1:0] RegGroupSize      = 2'd1;
  localparam logic [1:0] RegNumGroups      = 2'd2;
  localparam logic [1:0] RegNibbleMode     = 2'd3;

  typedef struct packed {
    logic [12:0] channels_per_row;
    logic [12:0] group_span;
    logic [8:0]  group_limit;
    logic        nibble_mode;
  } cfg_t;

  // One classified channel, as it waits between front and back
  typedef struct packed {
    logic [ElemW-1:0] elem;
    logic [GidxW-1:0] gidx;
    logic [BaseW-1:0] base;
    logic             grp_ok;
  } mid_item_t;

endpackage

// ----- src/group_index_channel_shuffle.sv -----
// Top level of the group index channel shuffle block: config registers and queues.
//
//   channel   handshake        payload
//   input     push / full      element_value, group_index
//   result    pop / empty      dest_position, byte_address, placed_value,
//                              upper_nibble, row_end, error_flag
//   config    cfg_write        cfg_index, cfg_data
//
// One item per cycle sustained while neither side stalls; a request passes the
// input queue, the counter stage and then the result queue to the result ports.
// The rate is set by the per-group counter read-modify-write, one table access
// per item with forwarding of the count just written.
// Reset clears the queues, the channel counter and all group valid bits; the
// counter table needs no clearing pass. Either side may stall on its own.
module group_index_channel_shuffle #(
  parameter int MAX_CHANNELS = 4096,
  parameter int MAX_GROUPS   = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [31:0]                     element_value,
  input  logic [11:0]                     group_index,
  output logic                            empty,
  input  logic                            pop,
  output logic [$clog2(MAX_CHANNELS)-1:0] dest_position,
  output logic [$clog2(MAX_CHANNELS)-1:0] byte_address,
  output logic [31:0]                     placed_value,
  output logic                            upper_nibble,
  output logic                            row_end,
  output logic                            error_flag,
  input  logic                            cfg_write,
  input  logic [1:0]                      cfg_index,
  input  logic [12:0]                     cfg_data
);

  localparam int PosW  = $clog2(MAX_CHANNELS);
  localparam int OutW  = 2 * PosW + gics_pkg::ElemW + 3;
  localparam int QCntW = $clog2(gics_pkg::QDepth + 1);
  localparam int MidW  = $bits(gics_pkg::mid_item_t);

  gics_pkg::cfg_t      cfg;
  gics_pkg::mid_item_t front_item;
  gics_pkg::mid_item_t mid_head;
  logic [MidW-1:0]     mid_rd;
  logic                mid_empty;
  logic                mid_pop;
  logic [QCntW-1:0]    mid_count;
  logic [QCntW-1:0]    out_count;
  logic                out_full;
  logic                res_valid;
  logic [PosW-1:0]     res_dest;
  logic [PosW-1:0]     res_byte;
  logic [31:0]         res_value;
  logic                res_upper;
  logic                res_row_end;
  logic                res_error;
  logic [OutW-1:0]     out_wr;
  logic [OutW-1:0]     out_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channels_per_row <= 13'd4096;
      cfg.group_span       <= 13'd128;
      cfg.group_limit      <= 9'd32;
      cfg.nibble_mode      <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        gics_pkg::RegChannelsPerRow: cfg.channels_per_row <= cfg_data;
        gics_pkg::RegGroupSize:      cfg.group_span       <= cfg_data;
        gics_pkg::RegNumGroups:      cfg.group_limit      <= cfg_data[8:0];
        gics_pkg::RegNibbleMode:     cfg.nibble_mode      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  gics_front #(
    .MAX_GROUPS(MAX_GROUPS)
  ) u_front (
    .cfg           (cfg),
    .element_value (element_value),
    .group_index   (group_index),
    .item          (front_item)
  );

  gics_fifo #(
    .WIDTH(MidW),
    .DEPTH(gics_pkg::QDepth)
  ) u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (front_item),
    .rd_en   (mid_pop),
    .rd_data (mid_rd),
    .full    (full),
    .empty   (mid_empty),
    .count   (mid_count)
  );

  assign mid_head = mid_rd;

  gics_back #(
    .MAX_CHANNELS(MAX_CHANNELS),
    .MAX_GROUPS  (MAX_GROUPS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head        (mid_head),
    .mid_empty   (mid_empty),
    .mid_pop     (mid_pop),
    .out_count   (out_count),
    .res_valid   (res_valid),
    .res_dest    (res_dest),
    .res_byte    (res_byte),
    .res_value   (res_value),
    .res_upper   (res_upper),
    .res_row_end (res_row_end),
    .res_error   (res_error)
  );

  assign out_wr = {res_dest, res_byte, res_value, res_upper, res_row_end, res_error};

  gics_fifo #(
    .WIDTH(OutW),
    .DEPTH(gics_pkg::QDepth)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_valid),
    .wr_data (out_wr),
    .rd_en   (pop),
    .rd_data (out_rd),
    .full    (out_full),
    .empty   (empty),
    .count   (out_count)
  );

  assign dest_position = out_rd[OutW-1 -: PosW];
  assign byte_address  = out_rd[OutW-PosW-1 -: PosW];
  assign placed_value  = out_rd[34:3];
  assign upper_nibble  = out_rd[2];
  assign row_end       = out_rd[1];
  assign error_flag    = out_rd[0];

endmodule

// ----- src/gics_fifo.sv -----
// Small register queue with full/empty flags and a fill count.
module gics_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [WIDTH-1:0]             wr_data,
  input  logic                         rd_en,
  output logic [WIDTH-1:0]             rd_data,
  output logic                         full,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CntW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CntW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

// ----- src/gics_front.sv -----
// Front end: range-checks the group index and forms the group base position.
module gics_front #(
  parameter int MAX_GROUPS = 256
) (
  input  gics_pkg::cfg_t                    cfg,
  input  logic [gics_pkg::ElemW-1:0]        element_value,
  input  logic [gics_pkg::GidxW-1:0]        group_index,
  output gics_pkg::mid_item_t               item
);

  logic in_range;

  assign in_range = (32'(group_index) < 32'(cfg.group_limit)) &&
                    (32'(group_index) < MAX_GROUPS);

  always_comb begin
    item.elem   = element_value;
    item.gidx   = group_index;
    item.grp_ok = in_range;
    // group base: g times the group span, registered by the queue before the add
    item.base   = gics_pkg::BaseW'(group_index) * gics_pkg::BaseW'(cfg.group_span);
  end

endmodule

// ----- src/gics_back.sv -----
// Back end: per-group fill counters, position and nibble placement, row tracking.
module gics_back #(
  parameter int MAX_CHANNELS = 4096,
  parameter int MAX_GROUPS   = 256
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  gics_pkg::cfg_t                         cfg,
  input  gics_pkg::mid_item_t                    head,
  input  logic                                   mid_empty,
  output logic                                   mid_pop,
  input  logic [$clog2(gics_pkg::QDepth+1)-1:0]  out_count,
  output logic                                   res_valid,
  output logic [$clog2(MAX_CHANNELS)-1:0]        res_dest,
  output logic [$clog2(MAX_CHANNELS)-1:0]        res_byte,
  output logic [gics_pkg::ElemW-1:0]             res_value,
  output logic                                   res_upper,
  output logic                                   res_row_end,
  output logic                                   res_error
);

  localparam int PosW = $clog2(MAX_CHANNELS);
  localparam int GrpW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int SumW = gics_pkg::BaseW + 1;
  localparam int CntW = gics_pkg::CountW;

  logic [CntW-1:0]        fill_mem [MAX_GROUPS];
  logic [CntW-1:0]        rd_data;
  logic [MAX_GROUPS-1:0]  grp_valid;

  logic                   s1_valid;
  gics_pkg::mid_item_t    s1_item;
  logic                   s1_hit;
  logic [CntW-1:0]        s1_fwd;
  logic [CntW-1:0]        chan_cnt;

  logic [GrpW-1:0]        idx;
  logic [GrpW-1:0]        head_idx;
  logic [CntW-1:0]        cnt;
  logic [CntW-1:0]        cnt_next;
  logic [SumW-1:0]        sum;
  logic                   err;
  logic                   row_end;
  logic                   wr_en;
  logic [PosW-1:0]        pos;

  assign idx      = s1_item.gidx[GrpW-1:0];
  assign head_idx = head.gidx[GrpW-1:0];

  // Pop only when the result queue can take this item and the one in flight
  assign mid_pop = !mid_empty &&
                   ((32'(out_count) + 32'(s1_valid)) < gics_pkg::QDepth);

  always_comb begin
    if (s1_hit) begin
      cnt = s1_fwd;
    end else if (grp_valid[idx]) begin
      cnt = rd_data;
    end else begin
      cnt = '0;
    end
    cnt_next = cnt + CntW'(1);
    sum      = SumW'(s1_item.base) + SumW'(cnt);
    err      = !s1_item.grp_ok || (cnt >= cfg.group_span) ||
               (32'(sum) >= MAX_CHANNELS);
    row_end  = ({1'b0, chan_cnt} + 14'd1) >= {1'b0, cfg.channels_per_row};
    wr_en    = s1_valid && !err;
    pos      = sum[PosW-1:0];
  end

  always_comb begin
    res_valid   = s1_valid;
    res_row_end = row_end;
    res_error   = err;
    res_dest    = '0;
    res_byte    = '0;
    res_value   = '0;
    res_upper   = 1'b0;
    if (!err) begin
      res_dest = pos;
      if (cfg.nibble_mode) begin
        res_byte  = pos >> 1;
        res_upper = pos[0];
        res_value = pos[0] ? ((s1_item.elem & gics_pkg::NibLow) << 4) & gics_pkg::NibHigh
                           : (s1_item.elem & gics_pkg::NibLow);
      end else begin
        res_byte  = pos;
        res_value = s1_item.elem;
      end
    end
  end

  // Read old count on pop, write the advanced count when the item completes without error
  always_ff @(posedge clk) begin
    if (mid_pop) begin
      rd_data <= fill_mem[head_idx];
    end
    if (wr_en) begin
      fill_mem[idx] <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_pop) begin
      s1_item <= head;
      s1_fwd  <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s1_hit    <= 1'b0;
      chan_cnt  <= '0;
      grp_valid <= '0;
    end else begin
      s1_valid <= mid_pop;
      // forward the count written this cycle to a follower on the same group
      s1_hit   <= mid_pop && wr_en && !row_end && (idx == head_idx);
      if (s1_valid) begin
        if (row_end) begin
          chan_cnt  <= '0;
          grp_valid <= '0;
        end else begin
          chan_cnt <= chan_cnt + CntW'(1);
          if (wr_en) begin
            grp_valid[idx] <= 1'b1;
          end
        end
      end
    end
  end

endmodule
